@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Same-cycle implication, checked through reset as well
`define ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ rtl/nam_pkg.sv @@
// Shared types and constants for the nonlinear audio mixer.
// No dependencies.
package nam_pkg;

   localparam int SampleBits = 16;
   localparam int QueueDepth = 4;
   localparam int QPtrBits   = $clog2(QueueDepth);
   localparam int QCntBits   = $clog2(QueueDepth + 1);

   localparam logic [1:0] MODE_FOLD = 2'd0;
   localparam logic [1:0] MODE_DUP  = 2'd1;
   localparam logic [1:0] MODE_MIX  = 2'd2;
   localparam logic [1:0] MODE_PASS = 2'd3;

   typedef enum logic [2:0] {
      OP_FOLD,
      OP_FOLD_EMIT,
      OP_EMIT,
      OP_DUP,
      OP_MIX,
      OP_PASS
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [SampleBits-1:0] first;
      logic [SampleBits-1:0] second;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

endpackage

@@ rtl/nam_front.sv @@
// Front end: mode register, input acceptance and classification into queue ops.
// Depends on nam_pkg.
module nam_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [1:0]                       csr_wr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [2*nam_pkg::SampleBits-1:0] req_tdata,
   input  logic                             req_tlast,
   input  logic                             req_tuser,
   input  nam_pkg::q_status_type            q_status,
   output logic                             push,
   output nam_pkg::entry_type               push_entry
);

   logic [1:0]      mode_ff, mode_in;
   logic            keep;
   nam_pkg::op_type op;

   always_comb begin
      mode_in = csr_wr_en ? csr_wr_data : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= nam_pkg::MODE_FOLD;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // an absent source that does not close the fold changes nothing: dropped here
   always_comb begin
      keep = 1'b1;
      op   = nam_pkg::OP_PASS;
      case (mode_ff)
         nam_pkg::MODE_FOLD: begin
            if (req_tuser && req_tlast) begin
               op = nam_pkg::OP_FOLD_EMIT;
            end else if (req_tuser) begin
               op = nam_pkg::OP_FOLD;
            end else if (req_tlast) begin
               op = nam_pkg::OP_EMIT;
            end else begin
               keep = 1'b0;
            end
         end
         nam_pkg::MODE_DUP:  op = nam_pkg::OP_DUP;
         nam_pkg::MODE_MIX:  op = nam_pkg::OP_MIX;
         nam_pkg::MODE_PASS: op = nam_pkg::OP_PASS;
         default:            op = nam_pkg::OP_PASS;
      endcase
   end

   assign req_tready        = ~q_status.full;
   assign push              = req_tvalid & req_tready & keep;
   assign push_entry.op     = op;
   assign push_entry.first  = req_tdata[nam_pkg::SampleBits-1:0];
   assign push_entry.second = req_tdata[2*nam_pkg::SampleBits-1:nam_pkg::SampleBits];

endmodule

@@ rtl/nam_queue.sv @@
// Short op queue between front and back end.
// Depends on nam_pkg.
module nam_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  nam_pkg::entry_type    push_entry,
   input  logic                  pop,
   output nam_pkg::entry_type    head_entry,
   output nam_pkg::q_status_type q_status
);

   localparam int PtrBits = nam_pkg::QPtrBits;
   localparam int CntBits = nam_pkg::QCntBits;

   nam_pkg::entry_type entries_ff [nam_pkg::QueueDepth];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PtrBits'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PtrBits'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntBits'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry         = entries_ff[rd_ptr_ff];
   assign q_status.not_empty = (count_ff != '0);
   assign q_status.full      = (count_ff == CntBits'(nam_pkg::QueueDepth));

endmodule

@@ rtl/nam_back.sv @@
// Back end: fold accumulator, mix unit and registered result stage.
// Depends on nam_pkg.
module nam_back (
   input  logic                          clock,
   input  logic                          reset,
   input  nam_pkg::q_status_type         q_status,
   input  nam_pkg::entry_type            head_entry,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [nam_pkg::SampleBits-1:0] rsp_tdata,
   output logic                          rsp_tlast,
   output logic                          rsp_tuser
);

   localparam int N = nam_pkg::SampleBits;
   localparam int W = N + 4;
   localparam logic signed [W-1:0] Half   = W'(1) <<< (N - 1);
   localparam logic signed [W-1:0] SatMax = Half - W'(1);
   localparam logic signed [W-1:0] SatMin = -Half;

   // offset both by one, product or 2(a+b)-ab-2, offset back, saturate
   function automatic logic [N-1:0] f_mix(input logic [N-1:0] x, input logic [N-1:0] y);
      logic [N-1:0]          a;
      logic [N-1:0]          b;
      logic [2*N-1:0]        prod;
      logic [N:0]            p;
      logic [N:0]            sum;
      logic signed [W-1:0]   r;
      logic [N-1:0]          res;
      a    = {~x[N-1], x[N-2:0]};
      b    = {~y[N-1], y[N-2:0]};
      prod = ((2*N)'(a) * (2*N)'(b)) + ((2*N)'(1) << (N - 2));
      p    = prod[2*N-1:N-1];
      sum  = (N+1)'(a) + (N+1)'(b);
      if (!a[N-1] && !b[N-1]) begin
         r = $signed(W'(p)) - Half;
      end else begin
         r = $signed({2'b00, sum, 1'b0}) - $signed(W'(p)) - Half - Half - Half;
      end
      if (r > SatMax) begin
         res = SatMax[N-1:0];
      end else if (r < SatMin) begin
         res = SatMin[N-1:0];
      end else begin
         res = r[N-1:0];
      end
      return res;
   endfunction

   logic [N-1:0] acc_ff, acc_in;
   logic         have_ff, have_in;
   logic         phase_ff, phase_in;
   logic         valid_ff, valid_in;
   logic [N-1:0] data_ff;
   logic         last_ff, nosrc_ff;

   logic         out_free, emit, out_last, out_nosrc;
   logic [N-1:0] out_data, mix_y, mix_r, fold_val;

   assign out_free = ~valid_ff | rsp_tready;
   assign mix_y    = (head_entry.op == nam_pkg::OP_MIX) ? head_entry.second : acc_ff;
   assign mix_r    = f_mix(head_entry.first, mix_y);
   assign fold_val = have_ff ? mix_r : head_entry.first;

   always_comb begin
      pop       = 1'b0;
      emit      = 1'b0;
      out_data  = head_entry.first;
      out_nosrc = 1'b0;
      out_last  = 1'b1;
      acc_in    = acc_ff;
      have_in   = have_ff;
      phase_in  = phase_ff;
      if (q_status.not_empty) begin
         case (head_entry.op)
            nam_pkg::OP_FOLD: begin
               pop     = 1'b1;
               acc_in  = fold_val;
               have_in = 1'b1;
            end
            nam_pkg::OP_FOLD_EMIT: begin
               if (out_free) begin
                  pop      = 1'b1;
                  emit     = 1'b1;
                  out_data = fold_val;
                  acc_in   = '0;
                  have_in  = 1'b0;
               end
            end
            nam_pkg::OP_EMIT: begin
               if (out_free) begin
                  pop       = 1'b1;
                  emit      = 1'b1;
                  out_data  = have_ff ? acc_ff : '0;
                  out_nosrc = ~have_ff;
                  acc_in    = '0;
                  have_in   = 1'b0;
               end
            end
            nam_pkg::OP_DUP: begin
               // two transfers per entry; phase marks the second
               if (out_free) begin
                  emit = 1'b1;
                  if (!phase_ff) begin
                     out_last = 1'b0;
                     phase_in = 1'b1;
                  end else begin
                     pop      = 1'b1;
                     phase_in = 1'b0;
                  end
               end
            end
            nam_pkg::OP_MIX: begin
               if (out_free) begin
                  pop      = 1'b1;
                  emit     = 1'b1;
                  out_data = mix_r;
               end
            end
            nam_pkg::OP_PASS: begin
               if (out_free) begin
                  pop  = 1'b1;
                  emit = 1'b1;
               end
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   assign valid_in = emit | (valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         have_ff  <= 1'b0;
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         have_ff  <= have_in;
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         data_ff  <= out_data;
         last_ff  <= out_last;
         nosrc_ff <= out_nosrc;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = nosrc_ff;

endmodule

@@ rtl/nonlinear_audio_mixer_unit.sv @@
// Nonlinear audio mixer for signed Q1.15 samples, top level.
// Usage:
//  req_ channel: one item per transfer; tdata holds the two samples, tuser
//    marks a present source, tlast the last source of a fold.
//  rsp_ channel: one mixed sample per transfer; tuser flags a fold with no
//    source, tlast the final result of an item.
//  csr_: mode register (0 fold, 1 mono to stereo, 2 stereo to mono, 3 pass
//    through), for the user to write only while the block is idle (no check).
// Flow: the front end classifies one item per cycle into a four-entry queue
// while req_tready is high; the back end's single mix unit (one 16x16 multiply)
// and the fold accumulator complete one entry per cycle while the result stage
// is free, and move it into the registered result stage on rsp_. Mono to stereo
// takes two result transfers per item; its entry is popped with the second.
// Stall: the result register holds while rsp_tready is low; the queue keeps
// taking items until it holds four, then req_tready drops.
// Reset clears the mode to fold, the accumulator, the queue pointers and count
// and the result valid flag; queue entries and result data are not reset.
// Depends on nam_pkg, nam_front, nam_queue and nam_back.
module nonlinear_audio_mixer_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [1:0]                       csr_wr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [2*nam_pkg::SampleBits-1:0] req_tdata,  // sample_first, sample_second
   input  logic                             req_tlast,  // last_source
   input  logic                             req_tuser,  // source_present
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [nam_pkg::SampleBits-1:0]   rsp_tdata,  // mixed_sample
   output logic                             rsp_tlast,  // last
   output logic                             rsp_tuser   // no_source
);

   nam_pkg::q_status_type q_status;
   nam_pkg::entry_type    push_entry;
   nam_pkg::entry_type    head_entry;
   logic                  push;
   logic                  pop;

   nam_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .q_status    (q_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   nam_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   nam_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ rtl/nam_checker.sv @@
// Port-level checks for the mixer top level, bound in below.
// Depends on nam_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nam_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [nam_pkg::SampleBits-1:0] rsp_tdata,
   input logic                           rsp_tlast,
   input logic                           rsp_tuser
);

   // an empty fold always reads as silence
   `ASSERT_NOW(a_nosrc_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "no_source with non-zero sample")

   // an empty fold is always a single, final transfer
   `ASSERT_NOW(a_nosrc_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast, "no_source without last")

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled result changed")

   `ASSERT_ALWAYS(a_reset_idle, clock, $past(reset), !rsp_tvalid, "result valid straight after reset")

endmodule

bind nonlinear_audio_mixer_unit nam_checker u_nam_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
